/* rtl/btffa_pkg.sv */
// shared types, constants and control structs for the block table allocator
`timescale 1ns / 1ps

package btffa_pkg;

    localparam int DATA_W         = 32;
    localparam int BYTES_W        = 23;
    localparam int CNT_CFG_W      = 11;
    localparam int ENTRY_W        = 3;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int BLOCK_SIZE_DEF = 4096;
    localparam int ADDRESS_WIDTH  = 32;

    localparam logic [DATA_W-1:0] ADDR_MASK = (ADDRESS_WIDTH >= DATA_W) ? {DATA_W{1'b1}} :
        DATA_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);

    localparam logic [DATA_W-1:0]    HEAP_BASE_RST   = '0;
    localparam logic [CNT_CFG_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    // entry mark bit positions
    localparam int MARK_TAKEN = 0;
    localparam int MARK_FIRST = 1;
    localparam int MARK_NEXT  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE   = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RCP,
        S_QUO,
        S_PRD,
        S_EVAL,
        S_SCAN,
        S_MARK,
        S_MUL,
        S_SUM,
        S_FREE_RD,
        S_FREE_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    clr_wr;
        logic    capture;
        logic    rcp_mul;
        logic    rcp_sum;
        logic    chk_mul;
        logic    scan_start;
        logic    scan_step;
        logic    mark_step;
        logic    free_start;
        logic    free_rd;
        logic    free_wr;
        logic    mul;
        logic    sum;
        logic    set_res;
        t_status res_status;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic kind_free;
        logic pre_bad;
        logic need_gt_count;
        logic free_bad_idx;
        logic scan_hit;
        logic scan_miss;
        logic mark_last;
        logic free_first_bad;
        logic free_more;
        logic out_free;
    } t_sts;

endpackage

/* rtl/btffa_ctrl.sv */
// controller state machine sequencing clear, decode, scan, mark and free
`timescale 1ns / 1ps

module btffa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  btffa_pkg::t_sts   i_sts,
    output btffa_pkg::t_cmd   o_cmd
);
    import btffa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_stall          = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RCP;
                end
            end
            S_RCP: begin
                if (i_sts.pre_bad) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_BAD;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rcp_mul = 1'b1;
                    n_state       = S_QUO;
                end
            end
            S_QUO: begin
                o_cmd.rcp_sum = 1'b1;
                n_state       = S_PRD;
            end
            S_PRD: begin
                o_cmd.chk_mul = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.kind_free) begin
                    if (i_sts.free_bad_idx) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_BAD;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.free_start = 1'b1;
                        n_state          = S_FREE_RD;
                    end
                end else begin
                    if (i_sts.need_gt_count) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NOMEM;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_miss) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOMEM;
                    n_state          = S_DONE;
                end
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DONE;
            end
            S_FREE_RD: begin
                o_cmd.free_rd = 1'b1;
                n_state       = S_FREE_EV;
            end
            S_FREE_EV: begin
                if (i_sts.free_first_bad) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_BAD;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.free_wr = 1'b1;
                    if (i_sts.free_more) begin
                        n_state = S_FREE_RD;
                    end else begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/btffa_dp.sv */
// datapath: block table memory, reciprocal decode, scan counters, address math and output register
`timescale 1ns / 1ps

module btffa_dp #(
    parameter int NUM_BLOCKS = btffa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_SIZE = btffa_pkg::BLOCK_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btffa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btffa_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                              i_kind,
    input  logic [btffa_pkg::BYTES_W-1:0]     i_request_bytes,
    input  logic [btffa_pkg::DATA_W-1:0]      i_free_address,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [btffa_pkg::DATA_W-1:0]      o_result_address,
    output logic [btffa_pkg::STATUS_W-1:0]    o_status,
    input  btffa_pkg::t_cmd                   i_cmd,
    output btffa_pkg::t_sts                   o_sts
);
    import btffa_pkg::*;

    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int CW  = $clog2(NUM_BLOCKS + 1);
    localparam int MW  = (CW > CNT_CFG_W) ? CW : CNT_CFG_W;
    localparam int BSW = $clog2(BLOCK_SIZE + 1);
    localparam int PW  = IW + BSW;
    localparam int SW  = ((PW > DATA_W) ? PW : DATA_W) + 1;

    // divide by block size as a multiply by a rounded-up reciprocal, split in two slices
    localparam int LBS = $clog2(BLOCK_SIZE);
    localparam int RSH = DATA_W + LBS;
    localparam int RLW = 17;
    localparam int RHW = DATA_W + 1 - RLW;
    localparam int PLW = DATA_W + RLW;
    localparam int PHW = DATA_W + RHW;
    localparam int QSW = 2 * DATA_W + 1;
    localparam logic [DATA_W:0] RCP = (DATA_W + 1)'(((64'd1 << RSH) + 64'(BLOCK_SIZE)
        - 64'd1) / 64'(BLOCK_SIZE));
    localparam logic [RLW-1:0] RCP_LO = RCP[RLW-1:0];
    localparam logic [RHW-1:0] RCP_HI = RCP[DATA_W:RLW];

    // configuration
    logic [DATA_W-1:0]    r_heap_base;
    logic [CNT_CFG_W-1:0] r_block_count;

    // block table
    logic [ENTRY_W-1:0] r_mem [NUM_BLOCKS];
    logic [ENTRY_W-1:0] r_rdata;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // transaction state
    logic              r_kind;
    logic              r_pre_bad;
    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_dvd;
    logic [PLW-1:0]    r_plo;
    logic [PHW-1:0]    r_phi;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_qbs;

    logic [CW-1:0]     r_need;
    logic [CW-1:0]     r_rd_ptr;
    logic              r_rvalid;
    logic [IW-1:0]     r_chk_ptr;
    logic [CW-1:0]     r_run;
    logic [IW-1:0]     r_start;
    logic [IW-1:0]     r_wr_ptr;
    logic [CW-1:0]     r_mark_i;
    logic [CW-1:0]     r_fptr;
    logic              r_ffirst;
    logic [PW-1:0]     r_prod;

    logic [DATA_W-1:0]   r_res_addr;
    t_status             r_res_status;
    logic                r_o_valid;
    logic [DATA_W-1:0]   r_out_addr;
    logic [STATUS_W-1:0] r_out_status;

    // combinational helpers
    logic [CW-1:0]     count_now;
    logic [QSW-1:0]    rcp_full;
    logic [QSW-1:0]    rcp_shr;
    logic              rem_nz;
    logic [DATA_W-1:0] need32;
    logic              ent_free;
    logic [CW-1:0]     run_inc;
    logic              chk_last;
    logic              scan_rd;
    logic              scan_hit;
    logic [IW-1:0]     hit_start;
    logic [CW:0]       fptr_inc;
    logic [ENTRY_W-1:0] mark_entry;
    logic [SW-1:0]     addr_sum;

    always_comb begin
        if (MW'(r_block_count) > MW'(NUM_BLOCKS)) begin
            count_now = CW'(NUM_BLOCKS);
        end else begin
            count_now = CW'(r_block_count);
        end
    end

    assign rcp_full = QSW'(r_plo) + (QSW'(r_phi) << RLW);
    assign rcp_shr  = rcp_full >> RSH;
    assign rem_nz   = (r_dvd != r_qbs);
    assign need32   = r_quo + DATA_W'(rem_nz);

    assign ent_free  = !r_rdata[MARK_TAKEN];
    assign run_inc   = r_run + CW'(1);
    assign chk_last  = (CW'(r_chk_ptr) + CW'(1)) == r_count;
    assign scan_rd   = i_cmd.scan_step && (r_rd_ptr < r_count);
    assign scan_hit  = r_rvalid && ent_free && (run_inc == r_need);
    assign hit_start = (r_run == '0) ? r_chk_ptr : r_start;
    assign fptr_inc  = {1'b0, r_fptr} + (CW + 1)'(1);

    always_comb begin
        mark_entry             = '0;
        mark_entry[MARK_TAKEN] = 1'b1;
        mark_entry[MARK_FIRST] = (r_mark_i == '0);
        mark_entry[MARK_NEXT]  = ((r_mark_i + CW'(1)) != r_need);
    end

    assign addr_sum = SW'(r_heap_base) + SW'(r_prod);

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_rd_ptr[IW-1:0];
        if (scan_rd) begin
            rd_en = 1'b1;
        end else if (i_cmd.free_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_fptr[IW-1:0];
        end
        wr_en   = 1'b0;
        wr_addr = r_wr_ptr;
        wr_data = '0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.mark_step) begin
            wr_en   = 1'b1;
            wr_data = mark_entry;
        end else if (i_cmd.free_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_fptr[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= HEAP_BASE_RST;
            r_block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEAP_BASE:   r_heap_base   <= i_cfg_data;
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[CNT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rvalid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_wr_ptr <= r_wr_ptr + IW'(1);
            end else if (i_cmd.mark_step) begin
                r_wr_ptr <= r_wr_ptr + IW'(1);
            end else if (i_cmd.scan_step && scan_hit) begin
                r_wr_ptr <= hit_start;
            end
            if (i_cmd.scan_start) begin
                r_rvalid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rvalid <= scan_rd;
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_count <= count_now;
            if (i_kind) begin
                r_pre_bad <= i_free_address < r_heap_base;
                r_dvd     <= i_free_address - r_heap_base;
            end else begin
                r_pre_bad <= (i_request_bytes == '0);
                r_dvd     <= DATA_W'(i_request_bytes);
            end
        end

        if (i_cmd.rcp_mul) begin
            r_plo <= PLW'(r_dvd) * PLW'(RCP_LO);
            r_phi <= PHW'(r_dvd) * PHW'(RCP_HI);
        end

        if (i_cmd.rcp_sum) begin
            r_quo <= rcp_shr[DATA_W-1:0];
        end

        if (i_cmd.chk_mul) begin
            r_qbs <= r_quo * DATA_W'(BLOCK_SIZE);
        end

        if (i_cmd.scan_start) begin
            r_need   <= need32[CW-1:0];
            r_rd_ptr <= '0;
            r_run    <= '0;
        end else if (i_cmd.scan_step) begin
            r_chk_ptr <= r_rd_ptr[IW-1:0];
            if (scan_rd) begin
                r_rd_ptr <= r_rd_ptr + CW'(1);
            end
            if (r_rvalid) begin
                if (!ent_free) begin
                    r_run <= '0;
                end else begin
                    r_run <= run_inc;
                    if (r_run == '0) begin
                        r_start <= r_chk_ptr;
                    end
                end
            end
        end

        if (i_cmd.scan_step && scan_hit) begin
            r_mark_i <= '0;
        end else if (i_cmd.mark_step) begin
            r_mark_i <= r_mark_i + CW'(1);
        end

        if (i_cmd.free_start) begin
            r_fptr   <= r_quo[CW-1:0];
            r_ffirst <= 1'b1;
        end else if (i_cmd.free_wr) begin
            r_fptr   <= fptr_inc[CW-1:0];
            r_ffirst <= 1'b0;
        end

        if (i_cmd.mul) begin
            r_prod <= PW'(r_start) * PW'(BLOCK_SIZE);
        end

        if (i_cmd.sum) begin
            r_res_addr   <= addr_sum[DATA_W-1:0] & ADDR_MASK;
            r_res_status <= ST_OK;
        end else if (i_cmd.set_res) begin
            r_res_addr   <= '0;
            r_res_status <= i_cmd.res_status;
        end

        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

    always_comb begin
        o_sts                = '0;
        o_sts.clr_last       = (r_wr_ptr == IW'(NUM_BLOCKS - 1));
        o_sts.kind_free      = r_kind;
        o_sts.pre_bad        = r_pre_bad;
        o_sts.need_gt_count  = need32 > DATA_W'(r_count);
        o_sts.free_bad_idx   = rem_nz || (r_quo >= DATA_W'(r_count));
        o_sts.scan_hit       = scan_hit;
        o_sts.scan_miss      = r_rvalid && !scan_hit && chk_last;
        o_sts.mark_last      = (r_mark_i + CW'(1)) == r_need;
        o_sts.free_first_bad = r_ffirst && !(r_rdata[MARK_TAKEN] && r_rdata[MARK_FIRST]);
        o_sts.free_more      = r_rdata[MARK_NEXT] && (fptr_inc < {1'b0, r_count});
        o_sts.out_free       = !r_o_valid || !i_stall;
    end

endmodule

/* rtl/block_table_first_fit_allocator.sv */
// top level of the first-fit block table heap allocator
`timescale 1ns / 1ps

// Request channel: i_valid / o_stall with i_kind, i_request_bytes, i_free_address.
// A transaction is taken when i_valid is high and o_stall is low. Kind 0 allocates
// the byte count rounded up to whole blocks, kind 1 frees an address handed out earlier.
// Response channel: o_valid / i_stall with o_result_address and o_status (0 ok,
// 1 no free run, 2 bad request); one response per request, in order.
// Configuration: i_cfg_we writes i_cfg_data to heap_base (index 0) or block_count
// (index 1); write only while no request is in flight.
// Timing: one request at a time. Rounding and address decode are sequenced as two
// reciprocal partial products, the quotient, a check product and the evaluation.
// The next request is taken in the cycle after the response loads.
// Reset: the table is cleared one entry per cycle, all NUM_BLOCKS entries, while o_stall
// stays high; the configuration returns to heap_base 0 and block_count 1024.
// A stalled response stays in the output register; the next request may be taken
// meanwhile and its response waits until the register is free.

module block_table_first_fit_allocator #(
    parameter int NUM_BLOCKS = btffa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_SIZE = btffa_pkg::BLOCK_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btffa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btffa_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic [btffa_pkg::BYTES_W-1:0]     i_request_bytes,
    input  logic [btffa_pkg::DATA_W-1:0]      i_free_address,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [btffa_pkg::DATA_W-1:0]      o_result_address,
    output logic [btffa_pkg::STATUS_W-1:0]    o_status
);
    import btffa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    btffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    btffa_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_request_bytes  (i_request_bytes),
        .i_free_address   (i_free_address),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

/* tb/block_table_first_fit_allocator_tb.sv */
// self-checking testbench for the first-fit block table allocator
`timescale 1ns / 1ps

module block_table_first_fit_allocator_tb;

    import btffa_pkg::*;

    localparam int unsigned TBL_DEPTH   = NUM_BLOCKS_DEF;
    localparam int unsigned BLK_BYTES   = BLOCK_SIZE_DEF;
    localparam int          GEN_VIEW    = 0;
    localparam int          DUT_VIEW    = 1;
    localparam logic        KIND_ALLOC  = 1'b0;
    localparam logic        KIND_FREE   = 1'b1;
    localparam int          CYCLE_LIMIT = 5_000_000;
    localparam int          HOLD_CYCLES = 3000;

    typedef struct packed {
        logic               kind;
        logic [BYTES_W-1:0] bytes;
        logic [DATA_W-1:0]  addr;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] addr;
        t_status           st;
    } t_resp;

    typedef enum {RX_FLOW, RX_COIN, RX_BUSY, RX_TOGGLE} t_rx_mode;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_HEAP_BASE;
    logic [DATA_W-1:0]    i_cfg_data      = '0;
    logic                 i_valid         = 1'b0;
    logic                 o_stall;
    logic                 i_kind          = KIND_ALLOC;
    logic [BYTES_W-1:0]   i_request_bytes = '0;
    logic [DATA_W-1:0]    i_free_address  = '0;
    logic                 o_valid;
    logic                 i_stall         = 1'b0;
    logic [DATA_W-1:0]    o_result_address;
    logic [STATUS_W-1:0]  o_status;

    // two copies of the allocator state: one plans stimulus, one checks the block
    logic [ENTRY_W-1:0]   blk_map [2][TBL_DEPTH];
    logic [DATA_W-1:0]    heap_base_m [2];
    logic [CNT_CFG_W-1:0] blk_count_m [2];

    t_req              req_q [$];
    t_resp             resp_q [$];
    logic [DATA_W-1:0] live_addrs [$];
    logic [DATA_W-1:0] freed_addrs [$];

    int       errors    = 0;
    int       n_planned = 0;
    int       n_checked = 0;
    int       cycle_cnt = 0;
    int       burst_left = 1;
    int       gap_left   = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    int       mode_left  = 0;
    t_rx_mode rx_mode    = RX_FLOW;

    block_table_first_fit_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS_DEF),
        .BLOCK_SIZE(BLOCK_SIZE_DEF)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_address(o_result_address),
        .o_status        (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned in_use(input int v);
        return (blk_count_m[v] > TBL_DEPTH) ? TBL_DEPTH : int'(blk_count_m[v]);
    endfunction

    function automatic void serve_request(input int v, input logic kind,
                                          input logic [BYTES_W-1:0] bytes,
                                          input logic [DATA_W-1:0] addr,
                                          output logic [DATA_W-1:0] res_addr,
                                          output t_status res_st);
        int unsigned        cnt, need, run, start, i, idx;
        logic [DATA_W-1:0]  off;
        logic [ENTRY_W-1:0] e;
        logic               more, found;
        cnt = in_use(v);
        res_addr = '0;
        run = 0;
        start = 0;
        found = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (bytes == '0) begin
                res_st = ST_BAD;
                return;
            end
            need = (32'(bytes) + BLK_BYTES - 1) / BLK_BYTES;
            if (need > cnt) begin
                res_st = ST_NOMEM;
                return;
            end
            for (i = 0; i < cnt; i++) begin
                if (blk_map[v][i][MARK_TAKEN]) begin
                    run = 0;
                end else begin
                    if (run == 0) start = i;
                    run++;
                    if (run == need) begin
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (!found) begin
                res_st = ST_NOMEM;
                return;
            end
            for (i = 0; i < need; i++) begin
                e = '0;
                e[MARK_TAKEN] = 1'b1;
                e[MARK_FIRST] = (i == 0);
                e[MARK_NEXT]  = (i + 1 < need);
                blk_map[v][start + i] = e;
            end
            res_addr = (heap_base_m[v] + DATA_W'(start * BLK_BYTES)) & ADDR_MASK;
            res_st = ST_OK;
        end else begin
            res_st = ST_BAD;
            if (addr < heap_base_m[v]) return;
            off = addr - heap_base_m[v];
            if (off % BLK_BYTES != 0) return;
            if (off / BLK_BYTES >= cnt) return;
            idx = off / BLK_BYTES;
            if (!(blk_map[v][idx][MARK_TAKEN] && blk_map[v][idx][MARK_FIRST])) return;
            for (i = idx; i < cnt; i++) begin
                more = blk_map[v][i][MARK_NEXT];
                blk_map[v][i] = '0;
                if (!more) break;
            end
            res_st = ST_OK;
        end
    endfunction

    function automatic void rebuild_live();
        int unsigned cnt;
        cnt = in_use(GEN_VIEW);
        live_addrs.delete();
        for (int unsigned i = 0; i < cnt; i++) begin
            if (blk_map[GEN_VIEW][i][MARK_TAKEN] && blk_map[GEN_VIEW][i][MARK_FIRST])
                live_addrs.push_back(heap_base_m[GEN_VIEW] + DATA_W'(i * BLK_BYTES));
        end
    endfunction

    function automatic void plan_request(input logic kind, input logic [BYTES_W-1:0] bytes,
                                         input logic [DATA_W-1:0] addr);
        logic [DATA_W-1:0] ra;
        t_status           rs;
        serve_request(GEN_VIEW, kind, bytes, addr, ra, rs);
        req_q.push_back('{kind: kind, bytes: bytes, addr: addr});
        n_planned++;
        if (rs == ST_OK) begin
            if (kind == KIND_ALLOC) begin
                live_addrs.push_back(ra);
            end else begin
                for (int i = 0; i < live_addrs.size(); i++) begin
                    if (live_addrs[i] == addr) begin
                        live_addrs.delete(i);
                        break;
                    end
                end
                freed_addrs.push_back(addr);
                if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
            end
        end
    endfunction

    function automatic void plan_random_request();
        int unsigned        cnt, need, r, top;
        logic [BYTES_W-1:0] junk_b;
        logic [DATA_W-1:0]  junk_a, a;
        cnt = in_use(GEN_VIEW);
        junk_b = BYTES_W'($urandom);
        junk_a = $urandom;
        r = $urandom_range(0, 99);
        if (r >= 50 && r < 85 && live_addrs.size() > 0) begin
            plan_request(KIND_FREE, junk_b,
                         live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
        end else if (r >= 85 && r < 90 && freed_addrs.size() > 0) begin
            plan_request(KIND_FREE, junk_b,
                         freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
        end else if (r >= 90 && r < 95 && live_addrs.size() > 0) begin
            // next block of a run, or a misaligned address inside one
            a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            a += $urandom_range(0, 1) ? BLK_BYTES : $urandom_range(1, BLK_BYTES - 1);
            plan_request(KIND_FREE, junk_b, a);
        end else if (r >= 95) begin
            plan_request(KIND_FREE, junk_b, junk_a);
        end else if (r < 3) begin
            plan_request(KIND_ALLOC, '0, junk_a);
        end else if (r < 6) begin
            plan_request(KIND_ALLOC, junk_b, junk_a);
        end else begin
            top = (cnt == 0) ? 1 : cnt;
            if (r >= 10 && top > 6) top = 6;
            need = $urandom_range(1, top);
            plan_request(KIND_ALLOC,
                         BYTES_W'((need - 1) * BLK_BYTES + $urandom_range(1, BLK_BYTES)),
                         junk_a);
        end
    endfunction

    task automatic write_cfg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        for (int v = 0; v < 2; v++) begin
            if (idx == CFG_HEAP_BASE) heap_base_m[v] = val;
            else blk_count_m[v] = val[CNT_CFG_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge i_clk); while (n_checked < n_planned);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] base, input logic [CNT_CFG_W-1:0] count,
                             input int n);
        write_cfg(CFG_HEAP_BASE, base);
        write_cfg(CFG_BLOCK_COUNT, DATA_W'(count));
        rebuild_live();
        repeat (n) plan_random_request();
        wait_drain();
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
            burst_left = 1;
        end else if (!i_valid || !o_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                i_kind          <= r.kind;
                i_request_bytes <= r.bytes;
                i_free_address  <= r.addr;
                i_valid         <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(20, 60);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 6);
                    gap_left = $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // response stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && n_checked >= 200) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FLOW: i_stall <= 1'b0;
                RX_COIN: i_stall <= 1'($urandom_range(0, 1));
                RX_BUSY: i_stall <= ($urandom_range(0, 9) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // prediction on each accepted request, comparison on each accepted response
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] ra;
        t_status           rs;
        t_resp             want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                serve_request(DUT_VIEW, i_kind, i_request_bytes, i_free_address, ra, rs);
                resp_q.push_back('{addr: ra, st: rs});
            end
            if (o_valid && !i_stall) begin
                if (resp_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, actual addr %h status %0d",
                             $time, o_result_address, o_status);
                end else begin
                    want = resp_q.pop_front();
                    if (o_result_address !== want.addr) begin
                        errors++;
                        $display("%0t: result_address expected %h actual %h",
                                 $time, want.addr, o_result_address);
                    end
                    if (o_status !== want.st) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, o_status);
                    end
                end
                n_checked++;
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("block_table_first_fit_allocator_tb: FAIL");
        $finish;
    end

    initial begin
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < TBL_DEPTH; i++) blk_map[v][i] = '0;
            heap_base_m[v] = HEAP_BASE_RST;
            blk_count_m[v] = BLOCK_COUNT_RST;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero size, roundings, short run, oversize, bad frees, full table
        plan_request(KIND_ALLOC, '0, $urandom);
        plan_request(KIND_ALLOC, BYTES_W'(1), $urandom);
        plan_request(KIND_ALLOC, BYTES_W'(BLK_BYTES), $urandom);
        plan_request(KIND_ALLOC, BYTES_W'(BLK_BYTES + 1), $urandom);
        plan_request(KIND_ALLOC, BYTES_W'(TBL_DEPTH * BLK_BYTES), $urandom);
        plan_request(KIND_ALLOC, '1, $urandom);
        plan_request(KIND_FREE, BYTES_W'($urandom), 32'd1);
        plan_request(KIND_FREE, BYTES_W'($urandom), DATA_W'(3 * BLK_BYTES));
        plan_request(KIND_FREE, BYTES_W'($urandom), DATA_W'(2 * BLK_BYTES));
        plan_request(KIND_FREE, BYTES_W'($urandom), DATA_W'(2 * BLK_BYTES));
        plan_request(KIND_FREE, BYTES_W'($urandom), DATA_W'(TBL_DEPTH * BLK_BYTES));
        plan_request(KIND_FREE, BYTES_W'($urandom), '1);
        plan_request(KIND_FREE, BYTES_W'($urandom), '0);
        plan_request(KIND_FREE, BYTES_W'($urandom), DATA_W'(BLK_BYTES));
        plan_request(KIND_ALLOC, BYTES_W'(TBL_DEPTH * BLK_BYTES), $urandom);
        plan_request(KIND_ALLOC, BYTES_W'(1), $urandom);
        plan_request(KIND_FREE, BYTES_W'($urandom), '0);
        plan_request(KIND_ALLOC, BYTES_W'(8 * BLK_BYTES), $urandom);
        wait_drain();

        // shrink the table under a live run: the free stops at the last entry in use
        write_cfg(CFG_BLOCK_COUNT, DATA_W'(4));
        plan_request(KIND_FREE, BYTES_W'($urandom), '0);
        plan_request(KIND_ALLOC, BYTES_W'(BLK_BYTES), $urandom);
        plan_request(KIND_FREE, BYTES_W'($urandom), DATA_W'(4 * BLK_BYTES));
        wait_drain();

        // no entries in use
        write_cfg(CFG_BLOCK_COUNT, '0);
        plan_request(KIND_ALLOC, '0, $urandom);
        plan_request(KIND_ALLOC, BYTES_W'(1), $urandom);
        plan_request(KIND_FREE, BYTES_W'($urandom), '0);
        wait_drain();

        run_phase(32'hffff_f000, 11'h7ff, 40);
        run_phase($urandom & ~DATA_W'(BLK_BYTES - 1), 11'd1, 30);
        run_phase($urandom, 11'd16, 70);
        run_phase($urandom & ~DATA_W'(BLK_BYTES - 1), CNT_CFG_W'($urandom_range(2, 64)), 80);
        run_phase('0, 11'd1024, 40);
        run_phase('1, 11'd8, 40);
        run_phase($urandom & ~DATA_W'(BLK_BYTES - 1), CNT_CFG_W'($urandom_range(2, 64)), 150);
        run_phase($urandom & ~DATA_W'(BLK_BYTES - 1), 11'd4, 80);
        run_phase($urandom & ~DATA_W'(BLK_BYTES - 1), CNT_CFG_W'($urandom_range(100, 300)), 50);

        repeat (50) @(posedge i_clk);
        if (errors == 0 && resp_q.size() == 0) begin
            $display("block_table_first_fit_allocator_tb: PASS");
        end else begin
            $display("block_table_first_fit_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/btffa_pkg.sv
rtl/btffa_ctrl.sv
rtl/btffa_dp.sv
rtl/block_table_first_fit_allocator.sv
tb/block_table_first_fit_allocator_tb.sv
